### design/assert_macros.svh
// Assertion macros shared by the PPM frame encoder modules.
// No dependencies; included by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

// The condition must never be true.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("forbidden condition seen");

`endif

### design/rcppm_pkg.sv
// Types, constants and helper functions of the RC PPM frame encoder.
// No dependencies; imported by every module of the block.
package rcppm_pkg;

    localparam int W_CHAN  = 5;
    localparam int W_WIDTH = 12;
    localparam int W_FRAME = 15;
    localparam int W_CORR  = 8;
    localparam int W_TIME  = 16;
    localparam int W_CFG_INDEX = 3;
    localparam int W_CFG_DATA  = 15;

    localparam logic [W_WIDTH-1:0] DEF_WIDTH_US = 12'd1500;

    // Register indexes of the configuration port.
    localparam logic [W_CFG_INDEX-1:0] CFG_ACTIVE   = 3'd0;
    localparam logic [W_CFG_INDEX-1:0] CFG_INTERVAL = 3'd1;
    localparam logic [W_CFG_INDEX-1:0] CFG_MIN      = 3'd2;
    localparam logic [W_CFG_INDEX-1:0] CFG_MAX      = 3'd3;
    localparam logic [W_CFG_INDEX-1:0] CFG_FRAME    = 3'd4;
    localparam logic [W_CFG_INDEX-1:0] CFG_SYNC     = 3'd5;
    localparam logic [W_CFG_INDEX-1:0] CFG_CORR     = 3'd6;

    typedef enum logic [1:0] {
        PH_START    = 2'd0,
        PH_INTERVAL = 2'd1,
        PH_PULSE    = 2'd2
    } t_phase;

    // What a compare event does, decided when the item is accepted.
    typedef enum logic [1:0] {
        K_START = 2'd0,
        K_GAP   = 2'd1,
        K_PULSE = 2'd2,
        K_SYNC  = 2'd3
    } t_kind;

    typedef struct packed {
        logic              valid;
        t_kind             kind;
    } t_s1;

    typedef struct packed {
        logic [W_CHAN-1:0]  active_channels;
        logic [W_WIDTH-1:0] interval_us;
        logic [W_WIDTH-1:0] min_width_us;
        logic [W_WIDTH-1:0] max_width_us;
        logic [W_FRAME-1:0] frame_len_us;
        logic [W_FRAME-1:0] sync_min_us;
        logic [W_CORR-1:0]  tick_correction;
    } t_cfg;

    typedef struct packed {
        logic        op;
        logic [3:0]  chan_index;
        logic [15:0] width_us;
    } t_in_item;

    typedef struct packed {
        logic        pin_level;
        logic [15:0] compare_ticks;
        logic        frame_done;
        logic [1:0]  phase;
    } t_out_item;

    // Twice the duration minus the correction, floored at zero. Twice a
    // 15-bit value always fits in 16 bits, so no upper saturation is needed.
    function automatic logic [15:0] ticks_for(input logic [W_FRAME-1:0] dur_us,
                                              input logic [W_CORR-1:0] corr);
        logic [15:0] v;
        v = {dur_us, 1'b0};
        if (v <= {8'd0, corr}) begin
            ticks_for = 16'd0;
        end else begin
            ticks_for = v - {8'd0, corr};
        end
    endfunction

endpackage

### design/rcppm_wmem.sv
// Channel width store: one synchronous memory with a registered read port.
// Depends on rcppm_pkg; entries never written read as the default width.
`include "assert_macros.svh"

module rcppm_wmem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_we,
    input  logic [AW-1:0]                i_waddr,
    input  logic [rcppm_pkg::W_WIDTH-1:0] i_wdata,
    input  logic                         i_re,
    input  logic [AW-1:0]                i_raddr,
    output logic [rcppm_pkg::W_WIDTH-1:0] o_rdata
);
    import rcppm_pkg::*;

    logic [W_WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]   r_vld;
    logic [W_WIDTH-1:0] r_rdata;
    logic               r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    // One valid bit per entry stands in for the reset value of the store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rvld <= r_vld[i_raddr];
            end
        end
    end

    assign o_rdata = r_rvld ? r_rdata : DEF_WIDTH_US;

    // The single port serves either a channel write or an event read.
    `ASSERT_NEVER(a_one_access, i_clk, i_rst_n, i_we && i_re)

endmodule

### design/rcppm_seq.sv
// Phase and channel sequencer: decides each compare event at acceptance.
// Depends on rcppm_pkg; drives the store read address and the event stage.
`include "assert_macros.svh"

module rcppm_seq #(
    parameter int AW = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_evt_acc,
    input  logic                       i_adv,
    input  logic [rcppm_pkg::W_CHAN:0] i_eff_count,
    output logic                       o_re,
    output logic [AW-1:0]              o_raddr,
    output rcppm_pkg::t_s1             o_s1
);
    import rcppm_pkg::*;

    t_phase            r_phase, n_phase;
    logic [W_CHAN-1:0] r_chan, n_chan;
    t_s1               r_s1;
    t_kind             kind;
    logic              chan_left;
    logic [W_CHAN:0]   chan_ext;

    assign chan_left = {1'b0, r_chan} < i_eff_count;
    assign chan_ext  = {1'b0, r_chan};

    always_comb begin
        n_phase = r_phase;
        n_chan  = r_chan;
        case (r_phase)
            PH_INTERVAL: begin
                if (chan_left) begin
                    n_phase = PH_PULSE;
                    n_chan  = r_chan + 1'b1;
                end else begin
                    n_phase = PH_START;
                    n_chan  = '0;
                end
            end
            PH_PULSE: begin
                n_phase = PH_INTERVAL;
            end
            default: begin
                n_phase = PH_INTERVAL;
                n_chan  = '0;
            end
        endcase
    end

    always_comb begin
        case (r_phase)
            PH_INTERVAL: kind = chan_left ? K_PULSE : K_SYNC;
            PH_PULSE:    kind = K_GAP;
            default:     kind = K_START;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_START;
            r_chan   <= '0;
            r_s1     <= '{valid: 1'b0, kind: K_START};
        end else begin
            if (i_evt_acc) begin
                r_phase  <= n_phase;
                r_chan   <= n_chan;
                r_s1     <= '{valid: 1'b1, kind: kind};
            end else if (i_adv) begin
                r_s1.valid <= 1'b0;
            end
        end
    end

    assign o_re    = i_evt_acc;
    assign o_raddr = chan_ext[AW-1:0];
    assign o_s1    = r_s1;

    `ASSERT_NEXT(a_pulse_to_gap, i_clk, i_rst_n,
        i_evt_acc && (r_phase == PH_PULSE), r_phase == PH_INTERVAL)
    `ASSERT_NEXT(a_sync_clears_chan, i_clk, i_rst_n,
        i_evt_acc && (kind == K_SYNC), (r_chan == '0) && (r_phase == PH_START))

endmodule

### design/rcppm_calc.sv
// Result stage: elapsed-time tracking, compare value and the output register.
// Depends on rcppm_pkg; consumes the event stage and the store read data.
`include "assert_macros.svh"

module rcppm_calc (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rcppm_pkg::t_s1                i_s1,
    input  logic [rcppm_pkg::W_WIDTH-1:0] i_rdata,
    input  rcppm_pkg::t_cfg               i_cfg,
    input  logic                          i_out_ready,
    output logic                          o_adv,
    output logic                          o_out_valid,
    output rcppm_pkg::t_out_item          o_out_item
);
    import rcppm_pkg::*;

    logic [W_TIME-1:0]  r_elapsed, n_elapsed;
    logic               r_out_valid;
    t_out_item          r_out, n_out;
    logic [W_WIDTH-1:0] pulse_us;
    logic [W_WIDTH-1:0] add_us;
    logic [W_TIME:0]    sum;
    logic [W_FRAME-1:0] rem_us;
    logic [W_FRAME-1:0] sync_us;
    logic [W_TIME:0]    frame_diff;

    assign o_adv = i_s1.valid && (!r_out_valid || i_out_ready);

    assign pulse_us = (i_rdata > i_cfg.interval_us) ? (i_rdata - i_cfg.interval_us) : '0;
    assign add_us   = (i_s1.kind == K_PULSE) ? pulse_us : i_cfg.interval_us;
    assign sum      = {1'b0, r_elapsed} + {5'd0, add_us};

    // Past the frame length the remainder counts as zero, so the minimum wins.
    assign frame_diff = {2'b0, i_cfg.frame_len_us} - {1'b0, r_elapsed};
    assign rem_us     = frame_diff[W_TIME] ? '0 : frame_diff[W_FRAME-1:0];
    assign sync_us    = (i_cfg.sync_min_us < rem_us) ? rem_us : i_cfg.sync_min_us;

    always_comb begin
        n_elapsed = r_elapsed;
        n_out     = '0;
        case (i_s1.kind)
            K_PULSE: begin
                n_out.compare_ticks = ticks_for({3'd0, pulse_us}, i_cfg.tick_correction);
                n_out.phase         = PH_PULSE;
                n_elapsed           = sum[W_TIME] ? '1 : sum[W_TIME-1:0];
            end
            K_SYNC: begin
                n_out.compare_ticks = ticks_for(sync_us, i_cfg.tick_correction);
                n_out.frame_done    = 1'b1;
                n_out.phase         = PH_START;
            end
            K_GAP: begin
                n_out.pin_level     = 1'b1;
                n_out.compare_ticks = ticks_for({3'd0, i_cfg.interval_us},
                                                i_cfg.tick_correction);
                n_out.phase         = PH_INTERVAL;
                n_elapsed           = sum[W_TIME] ? '1 : sum[W_TIME-1:0];
            end
            default: begin
                n_out.pin_level     = 1'b1;
                n_out.compare_ticks = ticks_for({3'd0, i_cfg.interval_us},
                                                i_cfg.tick_correction);
                n_out.phase         = PH_INTERVAL;
                n_elapsed           = {4'd0, i_cfg.interval_us};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed   <= '0;
            r_out_valid <= 1'b0;
        end else if (o_adv) begin
            r_elapsed   <= n_elapsed;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `ASSERT_IMPLY(a_done_is_sync, i_clk, i_rst_n,
        r_out_valid && r_out.frame_done,
        !r_out.pin_level && (r_out.phase == PH_START))

endmodule

### design/rc_ppm_frame_encoder_core.sv
// Top level of the RC PPM frame encoder: configuration registers and glue.
// Depends on rcppm_pkg, rcppm_wmem, rcppm_seq and rcppm_calc.
//
// The encoder takes one item per clock cycle when ready. A write item (op 0)
// clamps the requested width to the configured minimum and maximum and stores
// it in the channel width memory when accepted; it gives no result and is
// dropped when its channel is at or above the active count (capped at
// MAX_CHANS). A compare event item (op 1) advances the start, interval, pulse
// and sync sequence when accepted and reads the width memory for the channel
// in turn; the event kind and read data are registered, then the result is
// loaded into the output register once it is free or taken. The width memory
// has a single port and each item uses it at most once, which gives a rate of
// one item per cycle while ready; the output register decouples the two sides,
// so the input stays ready while a result waits, and it only drops ready when
// an event waits behind an output result that is not taken. Stored widths
// start at 1500 us through per-entry valid bits, so no clearing pass is needed
// after reset. Configuration registers are written through the plain write
// port and take effect at once; write them only while idle.
module rc_ppm_frame_encoder_core #(
    parameter int MAX_CHANS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rcppm_pkg::W_CFG_INDEX-1:0] i_cfg_index,
    input  logic [rcppm_pkg::W_CFG_DATA-1:0]  i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  rcppm_pkg::t_in_item               i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output rcppm_pkg::t_out_item              o_out_item
);
    import rcppm_pkg::*;

    // Address width of the width memory; a single channel still gets one bit.
    localparam int AW = (MAX_CHANS > 1) ? $clog2(MAX_CHANS) : 1;
    localparam logic [W_CHAN:0] MAX_C = (W_CHAN + 1)'(MAX_CHANS);

    t_cfg               r_cfg;
    logic [W_CHAN:0]    eff_count;
    logic               in_acc;
    logic               evt_acc;
    logic               wr_acc;
    logic [W_WIDTH-1:0] clamped;
    logic [W_CHAN:0]    idx_ext;
    logic               re;
    logic [AW-1:0]      raddr;
    logic [W_WIDTH-1:0] rdata;
    t_s1                s1;
    logic               adv;

    // Configuration registers; an index past the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_channels <= 5'd8;
            r_cfg.interval_us     <= 12'd300;
            r_cfg.min_width_us    <= 12'd1000;
            r_cfg.max_width_us    <= 12'd2200;
            r_cfg.frame_len_us    <= 15'd20000;
            r_cfg.sync_min_us     <= 15'd3000;
            r_cfg.tick_correction <= 8'd7;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ACTIVE:   r_cfg.active_channels <= i_cfg_data[W_CHAN-1:0];
                CFG_INTERVAL: r_cfg.interval_us     <= i_cfg_data[W_WIDTH-1:0];
                CFG_MIN:      r_cfg.min_width_us    <= i_cfg_data[W_WIDTH-1:0];
                CFG_MAX:      r_cfg.max_width_us    <= i_cfg_data[W_WIDTH-1:0];
                CFG_FRAME:    r_cfg.frame_len_us    <= i_cfg_data[W_FRAME-1:0];
                CFG_SYNC:     r_cfg.sync_min_us     <= i_cfg_data[W_FRAME-1:0];
                CFG_CORR:     r_cfg.tick_correction <= i_cfg_data[W_CORR-1:0];
                default: ;
            endcase
        end
    end

    // Active channel count, capped at the size of the width memory.
    assign eff_count = ({1'b0, r_cfg.active_channels} < MAX_C) ?
                       {1'b0, r_cfg.active_channels} : MAX_C;

    // The input stalls only when an event waits and the output cannot move.
    assign o_in_ready = !s1.valid || adv;
    assign in_acc     = i_in_valid && o_in_ready;
    assign evt_acc    = in_acc && i_in_item.op;

    // Lower clamp first: with min above max, only widths below min get min.
    always_comb begin
        if (i_in_item.width_us < {4'd0, r_cfg.min_width_us}) begin
            clamped = r_cfg.min_width_us;
        end else if (i_in_item.width_us > {4'd0, r_cfg.max_width_us}) begin
            clamped = r_cfg.max_width_us;
        end else begin
            clamped = i_in_item.width_us[W_WIDTH-1:0];
        end
    end

    assign idx_ext = {2'b00, i_in_item.chan_index};
    assign wr_acc  = in_acc && !i_in_item.op && (idx_ext < eff_count);

    rcppm_wmem #(
        .DEPTH (MAX_CHANS),
        .AW    (AW)
    ) u_wmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (wr_acc),
        .i_waddr (idx_ext[AW-1:0]),
        .i_wdata (clamped),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    rcppm_seq #(
        .AW (AW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt_acc   (evt_acc),
        .i_adv       (adv),
        .i_eff_count (eff_count),
        .o_re        (re),
        .o_raddr     (raddr),
        .o_s1        (s1)
    );

    rcppm_calc u_calc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1        (s1),
        .i_rdata     (rdata),
        .i_cfg       (r_cfg),
        .i_out_ready (i_out_ready),
        .o_adv       (adv),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

### dv/rc_ppm_frame_encoder_core_tb.sv
// Self-checking testbench for the RC PPM frame encoder core (rc_ppm_frame_encoder_core).
// Depends on rcppm_pkg and the design files; it needs no other input.
`timescale 1ns / 1ps

module rc_ppm_frame_encoder_core_tb;
    import rcppm_pkg::*;

    localparam int MAX_CHANS = 16;
    localparam int N_PHASES = 12;
    localparam int ITEMS_PER_PHASE = 130;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 4;

    // Item operations and the register index that does not exist.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVENT = 1'b1;
    localparam logic [W_CFG_INDEX-1:0] CFG_UNUSED = 3'd7;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [W_CFG_INDEX-1:0] cfg_index = '0;
    logic [W_CFG_DATA-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    t_in_item in_item = '0;
    logic out_ready = 1'b0;
    logic out_hold = 1'b0;
    logic hold_go = 1'b0;

    logic o_in_ready;
    logic o_out_valid;
    t_out_item o_out_item;

    // Items waiting for the driver, and results that the encoder still owes.
    t_in_item stim_q[$];
    t_out_item expected_q[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    int mismatches = 0;
    int results_checked = 0;
    int frames_closed = 0;
    int writes_sent = 0;
    int events_sent = 0;
    int stall_cycles = 0;

    // Shadow copy of the encoder: configuration, sequencer state and widths.
    t_cfg cur_cfg;
    t_phase enc_phase;
    logic [4:0] chan_count;
    logic [15:0] shadow_elapsed;
    logic [11:0] width_mem[MAX_CHANS];

    rc_ppm_frame_encoder_core #(
        .MAX_CHANS(MAX_CHANS)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(rst_n),
        .i_cfg_we(cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data),
        .i_in_valid(in_valid),
        .o_in_ready(o_in_ready),
        .i_in_item(in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_item(o_out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void reset_shadow();
        cur_cfg.active_channels = 5'd8;
        cur_cfg.interval_us = 12'd300;
        cur_cfg.min_width_us = 12'd1000;
        cur_cfg.max_width_us = 12'd2200;
        cur_cfg.frame_len_us = 15'd20000;
        cur_cfg.sync_min_us = 15'd3000;
        cur_cfg.tick_correction = 8'd7;
        enc_phase = PH_START;
        chan_count = '0;
        shadow_elapsed = '0;
        for (int i = 0; i < MAX_CHANS; i++) begin
            width_mem[i] = 12'd1500;
        end
    endfunction

    // Compare value in half-microsecond ticks, less the correction, floored at zero.
    function automatic logic [15:0] to_ticks(int unsigned dur_us);
        int unsigned v;
        v = dur_us * 2;
        if (v <= 32'(cur_cfg.tick_correction)) begin
            return 16'd0;
        end
        v = v - 32'(cur_cfg.tick_correction);
        return (v > 65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic void add_elapsed(int unsigned d);
        int unsigned s;
        s = 32'(shadow_elapsed) + d;
        shadow_elapsed = (s > 65535) ? 16'hFFFF : s[15:0];
    endfunction

    // Applies one accepted item to the shadow state and queues the result it owes.
    function automatic void encode_item(t_in_item it);
        t_out_item res;
        int unsigned eff, v, cw, pulse, rem, dur;
        eff = (32'(cur_cfg.active_channels) > MAX_CHANS) ?
              MAX_CHANS : 32'(cur_cfg.active_channels);
        if (it.op == OP_WRITE) begin
            writes_sent++;
            if (32'(it.chan_index) < eff) begin
                if (it.width_us < 16'(cur_cfg.min_width_us)) begin
                    v = 32'(cur_cfg.min_width_us);
                end else if (it.width_us > 16'(cur_cfg.max_width_us)) begin
                    v = 32'(cur_cfg.max_width_us);
                end else begin
                    v = 32'(it.width_us);
                end
                width_mem[it.chan_index] = v[11:0];
            end
            return;
        end
        events_sent++;
        res = '0;
        case (enc_phase)
            PH_INTERVAL: begin
                if (32'(chan_count) < eff) begin
                    cw = 32'(width_mem[chan_count[3:0]]);
                    pulse = (cw > 32'(cur_cfg.interval_us)) ?
                            cw - 32'(cur_cfg.interval_us) : 0;
                    res.pin_level = 1'b0;
                    res.compare_ticks = to_ticks(pulse);
                    add_elapsed(pulse);
                    enc_phase = PH_PULSE;
                    chan_count = chan_count + 5'd1;
                end else begin
                    // Once the frame is overrun the remainder counts as zero.
                    rem = (32'(cur_cfg.frame_len_us) > 32'(shadow_elapsed)) ?
                          32'(cur_cfg.frame_len_us) - 32'(shadow_elapsed) : 0;
                    dur = (32'(cur_cfg.sync_min_us) < rem) ? rem : 32'(cur_cfg.sync_min_us);
                    res.pin_level = 1'b0;
                    res.compare_ticks = to_ticks(dur);
                    res.frame_done = 1'b1;
                    enc_phase = PH_START;
                    chan_count = '0;
                end
            end
            PH_PULSE: begin
                res.pin_level = 1'b1;
                res.compare_ticks = to_ticks(32'(cur_cfg.interval_us));
                add_elapsed(32'(cur_cfg.interval_us));
                enc_phase = PH_INTERVAL;
            end
            default: begin
                chan_count = '0;
                res.pin_level = 1'b1;
                res.compare_ticks = to_ticks(32'(cur_cfg.interval_us));
                shadow_elapsed = 16'(cur_cfg.interval_us);
                enc_phase = PH_INTERVAL;
            end
        endcase
        res.phase = enc_phase;
        expected_q.push_back(res);
    endfunction

    // Driver: offers the next queued item, idling at random between items.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                encode_item(in_item);
            end
            if (in_valid && !o_in_ready) begin
                stall_cycles++;
            end
            if (!in_valid || o_in_ready) begin
                if (stim_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_item <= stim_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report_mismatch(input string what, input t_out_item want,
                                   input t_out_item got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s: expected pin %0b ticks %0d done %0b phase %0d,",
                     $realtime, what, want.pin_level, want.compare_ticks,
                     want.frame_done, want.phase);
            $display("    got pin %0b ticks %0d done %0b phase %0d",
                     got.pin_level, got.compare_ticks, got.frame_done, got.phase);
        end
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (expected_q.size() == 0) begin
            report_mismatch("result with nothing pending", '0, got);
            return;
        end
        want = expected_q.pop_front();
        results_checked++;
        if (got.frame_done === 1'b1) begin
            frames_closed++;
        end
        if (got.pin_level !== want.pin_level || got.compare_ticks !== want.compare_ticks ||
            got.frame_done !== want.frame_done || got.phase !== want.phase) begin
            report_mismatch("result mismatch", want, got);
        end
    endtask

    // Monitor: takes results at random and checks each one as it is taken.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                check_result(o_out_item);
            end
            out_ready <= !out_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Long output hold-off so that the encoder fills and pushes back on its input.
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        out_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        out_hold <= 1'b0;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic write_reg(input logic [W_CFG_INDEX-1:0] idx,
                             input logic [W_CFG_DATA-1:0] data);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_ACTIVE: cur_cfg.active_channels = data[W_CHAN-1:0];
            CFG_INTERVAL: cur_cfg.interval_us = data[W_WIDTH-1:0];
            CFG_MIN: cur_cfg.min_width_us = data[W_WIDTH-1:0];
            CFG_MAX: cur_cfg.max_width_us = data[W_WIDTH-1:0];
            CFG_FRAME: cur_cfg.frame_len_us = data[W_FRAME-1:0];
            CFG_SYNC: cur_cfg.sync_min_us = data[W_FRAME-1:0];
            CFG_CORR: cur_cfg.tick_correction = data[W_CORR-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input t_cfg s);
        write_reg(CFG_ACTIVE, W_CFG_DATA'(s.active_channels));
        write_reg(CFG_INTERVAL, W_CFG_DATA'(s.interval_us));
        write_reg(CFG_MIN, W_CFG_DATA'(s.min_width_us));
        write_reg(CFG_MAX, W_CFG_DATA'(s.max_width_us));
        write_reg(CFG_FRAME, W_CFG_DATA'(s.frame_len_us));
        write_reg(CFG_SYNC, W_CFG_DATA'(s.sync_min_us));
        write_reg(CFG_CORR, W_CFG_DATA'(s.tick_correction));
        // A write to the missing index must leave every register alone.
        write_reg(CFG_UNUSED, W_CFG_DATA'($urandom));
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Waits until every item is in and every result is out, then lets the
    // pipeline settle before the registers are touched.
    task automatic wait_quiet();
        while (stim_q.size() != 0 || in_valid || expected_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_in_item make_item(input logic op, input int unsigned idx,
                                           input int unsigned w);
        t_in_item it;
        it.op = op;
        it.chan_index = idx[3:0];
        it.width_us = w[15:0];
        return it;
    endfunction

    // Mostly compare events to keep frames turning, with width writes mixed in.
    function automatic t_in_item random_item();
        t_in_item it;
        it.op = ($urandom_range(99) < 65) ? OP_EVENT : OP_WRITE;
        it.chan_index = 4'($urandom_range(15));
        case ($urandom_range(3))
            0: it.width_us = 16'($urandom_range(65535));
            1: it.width_us = 16'($urandom_range(4095));
            2: it.width_us = 16'((32'(cur_cfg.min_width_us) + $urandom_range(2)) - 1);
            default: it.width_us = 16'((32'(cur_cfg.max_width_us) + $urandom_range(2)) - 1);
        endcase
        return it;
    endfunction

    function automatic t_cfg random_setting();
        t_cfg s;
        case ($urandom_range(9))
            0: s.active_channels = 5'd0;
            1: s.active_channels = 5'($urandom_range(31, 17));
            default: s.active_channels = 5'($urandom_range(16, 1));
        endcase
        s.interval_us = ($urandom_range(3) == 0) ? 12'($urandom_range(4095)) :
                                                   12'($urandom_range(600));
        s.min_width_us = 12'($urandom_range(2000));
        s.max_width_us = 12'($urandom_range(4095));
        s.frame_len_us = 15'($urandom_range(32767));
        s.sync_min_us = ($urandom_range(3) == 0) ? 15'($urandom_range(32767)) :
                                                   15'($urandom_range(8000));
        s.tick_correction = 8'($urandom_range(255));
        return s;
    endfunction

    function automatic t_cfg fixed_setting(input int n);
        t_cfg s;
        case (n)
            // Channel count above the store, widths no longer than the interval,
            // elapsed time saturating past the frame, correction eating each pulse.
            0: s = '{5'd31, 12'd4095, 12'd4095, 12'd4095, 15'd32767, 15'd32767, 8'd255};
            // No channels at all, minimum above maximum, zero-length sync.
            1: s = '{5'd0, 12'd4095, 12'd3000, 12'd100, 15'd0, 15'd0, 8'd255};
            // Full store, one-microsecond interval, widest clamp, longest frame.
            2: s = '{5'd16, 12'd1, 12'd0, 12'd4095, 15'd32767, 15'd0, 8'd0};
            // Every width clamped to zero, zero interval, long minimum sync.
            default: s = '{5'd16, 12'd0, 12'd0, 12'd0, 15'd0, 15'd32767, 8'd0};
        endcase
        return s;
    endfunction

    initial begin : stimulus
        t_cfg setting;
        reset_shadow();
        send_idle_pct = 16;
        recv_idle_pct = 79;
        repeat (5) @(posedge i_clk);
        rst_n <= 1'b1;

        // Directed frame under the reset settings: widths below, above and inside
        // the clamp, writes to the last active channel and beyond the count,
        // then one whole frame of eight channels through to its sync.
        stim_q.push_back(make_item(OP_EVENT, 0, 0));
        stim_q.push_back(make_item(OP_WRITE, 0, 0));
        stim_q.push_back(make_item(OP_WRITE, 1, 65535));
        stim_q.push_back(make_item(OP_WRITE, 2, 1234));
        stim_q.push_back(make_item(OP_WRITE, 7, 2200));
        stim_q.push_back(make_item(OP_WRITE, 8, 1700));
        stim_q.push_back(make_item(OP_WRITE, 15, 1100));
        repeat (17) stim_q.push_back(make_item(OP_EVENT, 15, 65535));

        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph == N_PHASES / 3) begin
                send_idle_pct = 79;
                recv_idle_pct = 16;
            end else if (ph == 2 * N_PHASES / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            setting = (ph < 4) ? fixed_setting(ph) : random_setting();
            wait_quiet();
            apply_setting(setting);
            if (ph == 2 * N_PHASES / 3) begin
                hold_go = 1'b1;
            end
            repeat (ITEMS_PER_PHASE) stim_q.push_back(random_item());
        end

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_q.size() != 0) begin
            report_mismatch("result never delivered", expected_q[0], '0);
        end

        $display("Covered %0d width writes and %0d compare events over %0d settings.",
                 writes_sent, events_sent, N_PHASES + 1);
        $display("Checked %0d results, %0d frame ends, input stalled %0d cycles.",
                 results_checked, frames_closed, stall_cycles);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches in total.", mismatches);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
